/* hdl/ucs_pkg.sv */
package ucs_pkg;

    // bit width of one URI character
    localparam int CHAR_W = 8;

    // result transaction layout, packed from the lowest bit up
    localparam int POS_W   = 9;
    localparam int STAT_W  = 2;
    localparam int RES_W   = STAT_W + 1 + 7 * POS_W;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    // marker characters
    localparam logic [CHAR_W-1:0] CH_COLON    = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_HASH     = 8'h23;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_AT       = 8'h40;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;

    // scheme check progress
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SCHEME,
        PH_DONE,
        PH_BAD
    } t_phase;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_BAD_SCHEME,
        ST_TOO_LONG
    } t_status;

    // end-of-string sequencer
    typedef enum logic [2:0] {
        SQ_LOAD,
        SQ_CHECK,
        SQ_READ2,
        SQ_AUTH,
        SQ_SCAN,
        SQ_SCAN_WAIT,
        SQ_FINISH
    } t_seq;

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_scheme_char(input logic [CHAR_W-1:0] c);
        return is_alpha(c) || (c >= 8'h30 && c <= 8'h39)
            || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
    endfunction

endpackage

/* hdl/ucs_track.sv */
module ucs_track #(
    parameter int MAX_LEN = 256,
    parameter int CW      = 9
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [ucs_pkg::CHAR_W-1:0] i_char,
    input  logic                       i_clear,
    output logic [CW-1:0]              o_count,
    output logic                       o_overflow,
    output ucs_pkg::t_phase            o_phase,
    output logic [CW-1:0]              o_scheme_end,
    output logic [CW-1:0]              o_last_hash,
    output logic [CW-1:0]              o_query_before_hash,
    output logic [CW-1:0]              o_last_question,
    output logic [CW-1:0]              o_first_slash,
    output logic [CW-1:0]              o_first_at
);

    logic [CW-1:0]   r_count, n_count;
    logic            r_overflow, n_overflow;
    ucs_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]   r_scheme_end, n_scheme_end;
    logic [CW-1:0]   r_last_hash, n_last_hash;
    logic [CW-1:0]   r_qbh, n_qbh;
    logic [CW-1:0]   r_last_q, n_last_q;
    logic [CW-1:0]   r_first_slash, n_first_slash;
    logic [CW-1:0]   r_first_at, n_first_at;
    logic [CW:0]     w_auth_min;
    logic            w_in_auth;

    // slash and '@' count only from the third byte after the scheme colon
    assign w_auth_min = {1'b0, r_scheme_end} + (CW+1)'(3);
    assign w_in_auth  = {1'b0, r_count} >= w_auth_min;

    // marker tracking per accepted byte
    always_comb begin
        n_count       = r_count;
        n_overflow    = r_overflow;
        n_phase       = r_phase;
        n_scheme_end  = r_scheme_end;
        n_last_hash   = r_last_hash;
        n_qbh         = r_qbh;
        n_last_q      = r_last_q;
        n_first_slash = r_first_slash;
        n_first_at    = r_first_at;
        if (i_clear) begin
            n_count       = '0;
            n_overflow    = 1'b0;
            n_phase       = ucs_pkg::PH_FIRST;
            n_scheme_end  = '0;
            n_last_hash   = '0;
            n_qbh         = '0;
            n_last_q      = '0;
            n_first_slash = '0;
            n_first_at    = '0;
        end else if (i_take) begin
            if (r_count < CW'(MAX_LEN)) begin
                n_count = r_count + 1'b1;
                case (r_phase)
                    ucs_pkg::PH_FIRST: begin
                        n_phase = ucs_pkg::is_alpha(i_char) ? ucs_pkg::PH_SCHEME
                                                            : ucs_pkg::PH_BAD;
                    end
                    ucs_pkg::PH_SCHEME: begin
                        if (i_char == ucs_pkg::CH_COLON) begin
                            n_phase      = ucs_pkg::PH_DONE;
                            n_scheme_end = r_count;
                        end else if (!ucs_pkg::is_scheme_char(i_char)) begin
                            n_phase = ucs_pkg::PH_BAD;
                        end
                    end
                    ucs_pkg::PH_DONE: begin
                        if (i_char == ucs_pkg::CH_HASH) begin
                            n_last_hash = r_count;
                            n_qbh       = r_last_q;
                        end else if (i_char == ucs_pkg::CH_QUESTION) begin
                            n_last_q = r_count;
                        end else if (i_char == ucs_pkg::CH_SLASH) begin
                            if (r_first_slash == '0 && w_in_auth) begin
                                n_first_slash = r_count;
                            end
                        end else if (i_char == ucs_pkg::CH_AT) begin
                            if (r_first_at == '0 && w_in_auth) begin
                                n_first_at = r_count;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_overflow = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_overflow    <= 1'b0;
            r_phase       <= ucs_pkg::PH_FIRST;
            r_scheme_end  <= '0;
            r_last_hash   <= '0;
            r_qbh         <= '0;
            r_last_q      <= '0;
            r_first_slash <= '0;
            r_first_at    <= '0;
        end else begin
            r_count       <= n_count;
            r_overflow    <= n_overflow;
            r_phase       <= n_phase;
            r_scheme_end  <= n_scheme_end;
            r_last_hash   <= n_last_hash;
            r_qbh         <= n_qbh;
            r_last_q      <= n_last_q;
            r_first_slash <= n_first_slash;
            r_first_at    <= n_first_at;
        end
    end

    assign o_count             = r_count;
    assign o_overflow          = r_overflow;
    assign o_phase             = r_phase;
    assign o_scheme_end        = r_scheme_end;
    assign o_last_hash         = r_last_hash;
    assign o_query_before_hash = r_qbh;
    assign o_last_question     = r_last_q;
    assign o_first_slash       = r_first_slash;
    assign o_first_at          = r_first_at;

endmodule

/* hdl/uri_component_splitter_top.sv */
// URI component splitter.
// Slave stream: one URI byte per transaction in i_s_tdata, i_s_tlast on the
// final byte. Master stream: one result transaction per string, sent after
// the final byte, with status and the component boundary positions.
// Bytes are taken one per cycle while o_s_tready is high; bytes beyond
// MAX_LEN are dropped and flagged as too long. The scheme check and the
// fragment, query, slash and '@' markers are tracked as the bytes arrive.
// After the final byte the sequencer reads the byte store: two reads for
// the "//" check, then a backward scan over the host part for the port
// colon, one byte at a time. A string with a length or scheme error skips
// the "//" check and the scan, a string without authority skips the scan.
// o_s_tready is low from the final byte until the result is loaded into
// the output register, and high for every byte in between.
// The result waits in an output register: a stalled receiver does not stop
// the next string from loading, only its finish waits for the register.
// Reset (synchronous, active low) empties the string state and the output
// register; the byte store needs no clearing, it is read only where written.
module uri_component_splitter_top #(
    parameter int MAX_LEN = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [ucs_pkg::CHAR_W-1:0]  i_s_tdata,   // [7:0] char_in
    input  logic                        i_s_tlast,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [1:0] status, [10:2] scheme_colon_pos, [11] has_authority,
    // [20:12] at_pos, [29:21] port_colon_pos, [38:30] path_start,
    // [47:39] query_pos, [56:48] fragment_pos, [65:57] total_length, rest 0
    output logic [ucs_pkg::TDATA_W-1:0] o_m_tdata
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = ucs_pkg::POS_W;

    // byte store
    logic [ucs_pkg::CHAR_W-1:0] r_mem [MAX_LEN];
    logic [ucs_pkg::CHAR_W-1:0] r_rd_data;
    logic [AW-1:0]              w_rd_addr;
    logic                       w_take;
    logic                       w_clear;

    // tracker state
    logic [CW-1:0]   w_count;
    logic            w_overflow;
    ucs_pkg::t_phase w_phase;
    logic [CW-1:0]   w_se;
    logic [CW-1:0]   w_last_hash;
    logic [CW-1:0]   w_qbh;
    logic [CW-1:0]   w_last_q;
    logic [CW-1:0]   w_first_slash;
    logic [CW-1:0]   w_first_at;

    // sequencer and result registers
    ucs_pkg::t_seq              r_seq, n_seq;
    ucs_pkg::t_status           r_status, n_status;
    logic                       r_auth, n_auth;
    logic [CW-1:0]              r_at, n_at;
    logic [CW-1:0]              r_port, n_port;
    logic [CW-1:0]              r_pstart, n_pstart;
    logic [CW-1:0]              r_scan, n_scan;
    logic [CW:0]                r_host, n_host;
    logic [ucs_pkg::CHAR_W-1:0] r_byte1, n_byte1;
    logic                       r_out_valid, n_out_valid;
    logic [ucs_pkg::TDATA_W-1:0] r_out_tdata, n_out_tdata;

    // derived boundaries
    logic [CW-1:0] w_query;
    logic [CW-1:0] w_end;
    logic [CW-1:0] w_pstart;
    logic [CW-1:0] w_at;
    logic [CW-1:0] w_scan_prev;
    logic [CW-1:0] w_se_p1;
    logic [CW:0]   w_se_p2;
    logic          w_auth;
    logic          w_ok;

    assign o_s_tready = (r_seq == ucs_pkg::SQ_LOAD);
    assign w_take     = i_s_tvalid && o_s_tready;

    ucs_track #(
        .MAX_LEN (MAX_LEN),
        .CW      (CW)
    ) u_track (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_take              (w_take),
        .i_char              (i_s_tdata),
        .i_clear             (w_clear),
        .o_count             (w_count),
        .o_overflow          (w_overflow),
        .o_phase             (w_phase),
        .o_scheme_end        (w_se),
        .o_last_hash         (w_last_hash),
        .o_query_before_hash (w_qbh),
        .o_last_question     (w_last_q),
        .o_first_slash       (w_first_slash),
        .o_first_at          (w_first_at)
    );

    // store write on accepted bytes within MAX_LEN, registered read
    always_ff @(posedge i_clk) begin
        if (w_take && w_count < CW'(MAX_LEN)) begin
            r_mem[w_count[AW-1:0]] <= i_s_tdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // component ends from the tracked markers
    assign w_query  = (w_last_hash != '0) ? w_qbh : w_last_q;
    assign w_end    = (w_query != '0) ? w_query
                    : ((w_last_hash != '0) ? w_last_hash : w_count);
    assign w_pstart = (w_first_slash != '0 && w_first_slash < w_end) ? w_first_slash
                                                                       : w_end;
    assign w_at     = (w_first_at != '0 && w_first_at < w_pstart) ? w_first_at : '0;
    assign w_se_p1  = w_se + 1'b1;
    assign w_se_p2  = {1'b0, w_se} + (CW+1)'(2);
    assign w_auth   = (w_se_p2 < {1'b0, w_end}) && r_byte1 == ucs_pkg::CH_SLASH
                      && r_rd_data == ucs_pkg::CH_SLASH;
    assign w_scan_prev = r_scan - 1'b1;
    assign w_ok     = (r_status == ucs_pkg::ST_OK);

    // sequencer: next state, store reads and result assembly
    always_comb begin
        n_seq       = r_seq;
        n_status    = r_status;
        n_auth      = r_auth;
        n_at        = r_at;
        n_port      = r_port;
        n_pstart    = r_pstart;
        n_scan      = r_scan;
        n_host      = r_host;
        n_byte1     = r_byte1;
        n_out_valid = r_out_valid;
        n_out_tdata = r_out_tdata;
        w_rd_addr   = '0;
        w_clear     = 1'b0;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_seq)
            ucs_pkg::SQ_LOAD: begin
                if (w_take && i_s_tlast) begin
                    n_seq = ucs_pkg::SQ_CHECK;
                end
            end
            ucs_pkg::SQ_CHECK: begin
                n_auth   = 1'b0;
                n_at     = '0;
                n_port   = '0;
                n_pstart = '0;
                w_rd_addr = w_se_p1[AW-1:0];
                if (w_overflow) begin
                    n_status = ucs_pkg::ST_TOO_LONG;
                    n_seq    = ucs_pkg::SQ_FINISH;
                end else if (w_phase != ucs_pkg::PH_DONE) begin
                    n_status = ucs_pkg::ST_BAD_SCHEME;
                    n_seq    = ucs_pkg::SQ_FINISH;
                end else begin
                    n_status = ucs_pkg::ST_OK;
                    n_seq    = ucs_pkg::SQ_READ2;
                end
            end
            ucs_pkg::SQ_READ2: begin
                w_rd_addr = w_se_p2[AW-1:0];
                n_byte1   = r_rd_data;
                n_seq     = ucs_pkg::SQ_AUTH;
            end
            ucs_pkg::SQ_AUTH: begin
                if (w_auth) begin
                    n_auth   = 1'b1;
                    n_pstart = w_pstart;
                    n_at     = w_at;
                    n_scan   = w_pstart;
                    n_host   = (w_at != '0) ? ({1'b0, w_at} + (CW+1)'(1))
                                            : ({1'b0, w_se} + (CW+1)'(3));
                    n_seq    = ucs_pkg::SQ_SCAN;
                end else begin
                    n_pstart = w_se_p1;
                    n_seq    = ucs_pkg::SQ_FINISH;
                end
            end
            ucs_pkg::SQ_SCAN: begin
                w_rd_addr = w_scan_prev[AW-1:0];
                if ({1'b0, r_scan} > r_host) begin
                    n_seq = ucs_pkg::SQ_SCAN_WAIT;
                end else begin
                    n_seq = ucs_pkg::SQ_FINISH;
                end
            end
            ucs_pkg::SQ_SCAN_WAIT: begin
                if (r_rd_data == ucs_pkg::CH_COLON) begin
                    n_port = w_scan_prev;
                    n_seq  = ucs_pkg::SQ_FINISH;
                end else begin
                    n_scan = w_scan_prev;
                    n_seq  = ucs_pkg::SQ_SCAN;
                end
            end
            ucs_pkg::SQ_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = ucs_pkg::TDATA_W'({
                        PW'(w_count),
                        w_ok ? PW'(w_last_hash) : PW'(0),
                        w_ok ? PW'(w_query)     : PW'(0),
                        w_ok ? PW'(r_pstart)    : PW'(0),
                        w_ok ? PW'(r_port)      : PW'(0),
                        w_ok ? PW'(r_at)        : PW'(0),
                        w_ok && r_auth,
                        w_ok ? PW'(w_se)        : PW'(0),
                        r_status
                    });
                    w_clear = 1'b1;
                    n_seq   = ucs_pkg::SQ_LOAD;
                end
            end
            default: begin
                n_seq = ucs_pkg::SQ_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= ucs_pkg::SQ_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
        r_status    <= n_status;
        r_auth      <= n_auth;
        r_at        <= n_at;
        r_port      <= n_port;
        r_pstart    <= n_pstart;
        r_scan      <= n_scan;
        r_host      <= n_host;
        r_byte1     <= n_byte1;
        r_out_tdata <= n_out_tdata;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;

endmodule

/* tb/sv/uri_component_splitter_top_test.sv */
`timescale 1ns / 100ps

module uri_component_splitter_top_test;

    localparam int URI_MAX = 256;
    localparam int RANDOM_CHARS = 1250;

    // one split result as it sits on o_m_tdata, top field first
    typedef struct packed {
        logic [5:0] pad;
        logic [8:0] total_length;
        logic [8:0] fragment_pos;
        logic [8:0] query_pos;
        logic [8:0] path_start;
        logic [8:0] port_colon_pos;
        logic [8:0] at_pos;
        logic       has_authority;
        logic [8:0] scheme_colon_pos;
        ucs_pkg::t_status status;
    } t_split;

    typedef logic [7:0] t_bytes[$];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [ucs_pkg::CHAR_W-1:0] i_s_tdata = '0;   // [7:0] char_in
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    // [1:0] status, [10:2] scheme_colon_pos, [11] has_authority,
    // [20:12] at_pos, [29:21] port_colon_pos, [38:30] path_start,
    // [47:39] query_pos, [56:48] fragment_pos, [65:57] total_length, rest 0
    logic [ucs_pkg::TDATA_W-1:0] o_m_tdata;

    int send_idle_pct = 6;
    int recv_stall_pct = 70;

    // tracks the string being received and predicts its component split
    class uri_split_board;
        logic [7:0]  chars [URI_MAX];
        int unsigned n_chars;
        bit          too_long;
        ucs_pkg::t_phase phase;
        int unsigned colon_at;
        int unsigned hash_at;
        int unsigned query_at_hash;
        int unsigned question_at;
        int unsigned slash_at;
        int unsigned at_sign_at;
        t_split      expected_splits[$];
        int unsigned failures;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            n_chars = 0;
            too_long = 1'b0;
            phase = ucs_pkg::PH_FIRST;
            colon_at = 0;
            hash_at = 0;
            query_at_hash = 0;
            question_at = 0;
            slash_at = 0;
            at_sign_at = 0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
        endfunction

        function bit is_scheme_byte(logic [7:0] c);
            return is_letter(c) || (c >= 8'h30 && c <= 8'h39)
                || c == ucs_pkg::CH_PLUS || c == ucs_pkg::CH_MINUS
                || c == ucs_pkg::CH_DOT;
        endfunction

        // positions past the store read as zero
        function logic [7:0] char_at(int unsigned pos);
            return pos < URI_MAX ? chars[pos] : 8'h00;
        endfunction

        function string show(t_split s);
            return $sformatf("st=%0d colon=%0d auth=%0d at=%0d port=%0d path=%0d q=%0d f=%0d len=%0d pad=%0h",
                s.status, s.scheme_colon_pos, s.has_authority, s.at_pos,
                s.port_colon_pos, s.path_start, s.query_pos, s.fragment_pos,
                s.total_length, s.pad);
        endfunction

        // accepted input byte; on the last byte the split is predicted
        function void note_char(logic [7:0] c, logic last);
            t_split      want;
            int unsigned query;
            int unsigned path_end;
            int unsigned pstart;
            int unsigned host;
            int unsigned k;

            if (n_chars < URI_MAX) begin
                chars[n_chars] = c;
                case (phase)
                    ucs_pkg::PH_FIRST: begin
                        phase = is_letter(c) ? ucs_pkg::PH_SCHEME : ucs_pkg::PH_BAD;
                    end
                    ucs_pkg::PH_SCHEME: begin
                        if (c == ucs_pkg::CH_COLON) begin
                            phase = ucs_pkg::PH_DONE;
                            colon_at = n_chars;
                        end else if (!is_scheme_byte(c)) begin
                            phase = ucs_pkg::PH_BAD;
                        end
                    end
                    ucs_pkg::PH_DONE: begin
                        if (c == ucs_pkg::CH_HASH) begin
                            hash_at = n_chars;
                            query_at_hash = question_at;
                        end else if (c == ucs_pkg::CH_QUESTION) begin
                            question_at = n_chars;
                        end else if (c == ucs_pkg::CH_SLASH) begin
                            if (slash_at == 0 && n_chars >= colon_at + 3)
                                slash_at = n_chars;
                        end else if (c == ucs_pkg::CH_AT) begin
                            if (at_sign_at == 0 && n_chars >= colon_at + 3)
                                at_sign_at = n_chars;
                        end
                    end
                    default: begin
                    end
                endcase
                n_chars++;
            end else begin
                too_long = 1'b1;
            end
            if (!last)
                return;

            want = '0;
            want.total_length = 9'(n_chars);
            if (too_long) begin
                want.status = ucs_pkg::ST_TOO_LONG;
            end else if (phase != ucs_pkg::PH_DONE) begin
                want.status = ucs_pkg::ST_BAD_SCHEME;
            end else begin
                query = hash_at != 0 ? query_at_hash : question_at;
                path_end = query != 0 ? query : (hash_at != 0 ? hash_at : n_chars);
                want.status = ucs_pkg::ST_OK;
                want.scheme_colon_pos = 9'(colon_at);
                want.query_pos = 9'(query);
                want.fragment_pos = 9'(hash_at);
                if (colon_at + 2 < path_end && char_at(colon_at + 1) == ucs_pkg::CH_SLASH
                        && char_at(colon_at + 2) == ucs_pkg::CH_SLASH) begin
                    want.has_authority = 1'b1;
                    pstart = (slash_at != 0 && slash_at < path_end) ? slash_at : path_end;
                    if (at_sign_at != 0 && at_sign_at < pstart)
                        want.at_pos = 9'(at_sign_at);
                    host = want.at_pos != 0 ? at_sign_at + 1 : colon_at + 3;
                    // last colon of the host part, scanning backward
                    for (k = pstart; k > host; k--) begin
                        if (char_at(k - 1) == ucs_pkg::CH_COLON) begin
                            want.port_colon_pos = 9'(k - 1);
                            break;
                        end
                    end
                end else begin
                    pstart = colon_at + 1;
                end
                want.path_start = 9'(pstart);
            end
            expected_splits.push_back(want);
            restart();
        endfunction

        function void check_split(logic [ucs_pkg::TDATA_W-1:0] raw);
            t_split got;
            t_split want;

            got = raw;
            if (expected_splits.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected split result: %s", show(got));
                return;
            end
            want = expected_splits.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= 10) begin
                    $display("split mismatch, expected %s", show(want));
                    $display("                    got %s", show(got));
                end
            end
        endfunction
    endclass

    uri_split_board board;

    uri_component_splitter_top #(
        .MAX_LEN(URI_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // receiver stalls at random
    always @(negedge i_clk) begin
        i_m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // result transactions go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_split(o_m_tdata);
    end

    // ---- character pickers ----
    function automatic logic [7:0] alnum_char();
        int k;
        k = $urandom_range(61);
        if (k < 26)
            return 8'h41 + 8'(k);          // A..Z
        else if (k < 52)
            return 8'h61 + 8'(k - 26);     // a..z
        return 8'h30 + 8'(k - 52);         // 0..9
    endfunction

    function automatic logic [7:0] marker_char();
        case ($urandom_range(7))
            0: return ucs_pkg::CH_COLON;
            1: return ucs_pkg::CH_SLASH;
            2: return ucs_pkg::CH_AT;
            3: return ucs_pkg::CH_QUESTION;
            4: return ucs_pkg::CH_HASH;
            5: return ucs_pkg::CH_DOT;
            6: return ucs_pkg::CH_MINUS;
            default: return ucs_pkg::CH_PLUS;
        endcase
    endfunction

    // component text: mostly alphanumerics, markers fairly often, any nonzero byte now and then
    function automatic logic [7:0] content_char();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return alnum_char();
        else if (r < 85)
            return marker_char();
        return 8'($urandom_range(255, 1));
    endfunction

    function automatic void add_content(ref t_bytes s, input int n);
        repeat (n) s.push_back(content_char());
    endfunction

    function automatic void add_text(ref t_bytes s, input string t);
        for (int i = 0; i < t.len(); i++)
            s.push_back(t[i]);
    endfunction

    // ---- URI builders ----
    function automatic void build_uri(ref t_bytes s);
        int kind;
        int r;

        kind = $urandom_range(99);
        if (kind < 75) begin
            // well-formed shape, random content
            s.push_back($urandom_range(1) ? 8'h41 + 8'($urandom_range(25))
                                          : 8'h61 + 8'($urandom_range(25)));
            repeat ($urandom_range(6)) begin
                r = $urandom_range(99);
                if (r < 80)
                    s.push_back(alnum_char());
                else if (r < 87)
                    s.push_back(ucs_pkg::CH_PLUS);
                else if (r < 94)
                    s.push_back(ucs_pkg::CH_MINUS);
                else
                    s.push_back(ucs_pkg::CH_DOT);
            end
            s.push_back(ucs_pkg::CH_COLON);
            if ($urandom_range(99) < 70) begin
                add_text(s, "//");
                if ($urandom_range(99) < 40) begin
                    add_content(s, $urandom_range(5));
                    s.push_back(ucs_pkg::CH_AT);
                end
                repeat ($urandom_range(8)) begin
                    r = $urandom_range(99);
                    if (r < 70)
                        s.push_back(alnum_char());
                    else if (r < 85)
                        s.push_back(ucs_pkg::CH_DOT);
                    else if (r < 92)
                        s.push_back(ucs_pkg::CH_COLON);
                    else
                        s.push_back(content_char());
                end
                if ($urandom_range(99) < 40) begin
                    s.push_back(ucs_pkg::CH_COLON);
                    repeat ($urandom_range(4)) s.push_back(8'h30 + 8'($urandom_range(9)));
                end
            end
            if ($urandom_range(99) < 60) begin
                s.push_back(ucs_pkg::CH_SLASH);
                add_content(s, $urandom_range(8));
            end else if ($urandom_range(99) < 30) begin
                add_content(s, $urandom_range(1, 6));
            end
            if ($urandom_range(99) < 40) begin
                s.push_back(ucs_pkg::CH_QUESTION);
                add_content(s, $urandom_range(6));
            end
            if ($urandom_range(99) < 35) begin
                s.push_back(ucs_pkg::CH_HASH);
                add_content(s, $urandom_range(6));
            end
        end else if (kind < 90) begin
            // broken scheme
            case ($urandom_range(2))
                0: begin
                    // first byte not a letter
                    r = $urandom_range(2);
                    if (r == 0)
                        s.push_back(8'h30 + 8'($urandom_range(9)));
                    else if (r == 1)
                        s.push_back(marker_char());
                    else
                        s.push_back(8'($urandom_range(255, 8'h7B)));
                    add_content(s, $urandom_range(6));
                    s.push_back(ucs_pkg::CH_COLON);
                    add_content(s, $urandom_range(6));
                end
                1: begin
                    // bad byte inside the scheme
                    s.push_back(alnum_char() | 8'h40);
                    repeat ($urandom_range(3)) s.push_back(alnum_char());
                    case ($urandom_range(4))
                        0: s.push_back(8'h5F);         // underscore
                        1: s.push_back(ucs_pkg::CH_SLASH);
                        2: s.push_back(ucs_pkg::CH_AT);
                        3: s.push_back(ucs_pkg::CH_QUESTION);
                        default: s.push_back(8'($urandom_range(255, 8'h80)));
                    endcase
                    s.push_back(ucs_pkg::CH_COLON);
                    add_content(s, $urandom_range(6));
                end
                default: begin
                    // no colon at all
                    s.push_back(8'h61 + 8'($urandom_range(25)));
                    repeat ($urandom_range(10)) s.push_back(alnum_char());
                end
            endcase
        end else begin
            // noise
            repeat ($urandom_range(16, 1)) s.push_back(8'($urandom_range(255, 1)));
        end
    endfunction

    // long authority string, for the length limit and the longest port scan
    function automatic void build_long_uri(ref t_bytes s, input int len);
        add_text(s, "x://");
        while (s.size() < len)
            s.push_back($urandom_range(99) < 2 ? ucs_pkg::CH_COLON : alnum_char());
    endfunction

    // ---- stream driver ----
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata = c;
        i_s_tlast = last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_char(c, last);
        @(negedge i_clk);
    endtask

    task automatic send_uri(input t_bytes s);
        for (int i = 0; i < s.size(); i++)
            send_char(s[i], i == s.size() - 1);
    endtask

    task automatic send_text(input string t);
        t_bytes s;
        add_text(s, t);
        send_uri(s);
    endtask

    // ---- main sequence ----
    initial begin
        t_bytes s;
        int     random_sent;
        int     n_uri;

        board = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // shortest valid, bad first byte, missing colon, bad scheme byte
        send_text("a:");
        send_text("9:");
        send_text("ab");
        send_text("a_:");
        // every component present, with empty query and fragment
        send_text("s://u@h:8/?#");
        // top and lowest nonzero byte values
        s = {};
        add_text(s, "Z:");
        s.push_back(8'hFF);
        s.push_back(8'h01);
        send_uri(s);

        random_sent = 0;
        n_uri = 0;
        while (random_sent < RANDOM_CHARS) begin
            if (random_sent >= 2 * RANDOM_CHARS / 3) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end else if (random_sent >= RANDOM_CHARS / 3) begin
                send_idle_pct = 70;
                recv_stall_pct = 6;
            end
            s = {};
            if (n_uri == 5)
                build_long_uri(s, $urandom_range(URI_MAX, URI_MAX - 2));
            else if (n_uri == 30)
                build_long_uri(s, $urandom_range(URI_MAX + 14, URI_MAX + 1));
            else
                build_uri(s);
            send_uri(s);
            random_sent += s.size();
            n_uri++;
        end
        i_s_tvalid = 1'b0;
        i_s_tlast = 1'b0;

        while (board.expected_splits.size() != 0) @(posedge i_clk);
        repeat (2 * URI_MAX + 16) @(posedge i_clk);
        if (board.failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #6000000;
        $display("tb: failure");
        $finish;
    end

endmodule
